>>> design/fir7_decimate3_gain_macros.svh
// Assertion helpers used by fir7_decimate3_gain.
`ifndef FIR7_DECIMATE3_GAIN_MACROS_SVH
`define FIR7_DECIMATE3_GAIN_MACROS_SVH

`ifndef SYNTHESIS
`define FDG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FDG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define FDG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FDG_ASSERT(lbl, clk, rstn, prop, msg)
`define FDG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define FDG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/fdg_pkg.sv
package fdg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 20;  // 16 * full-scale sample fits
  localparam int TAP_COUNT  = 7;
  localparam int HIST_DEPTH = 6;
  localparam int WEIGHT_W   = 3;
  localparam int NORM_SHIFT = 4;   // divide by 16
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 8;   // Q8.8
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W   = PROD_W - GAIN_SHIFT;
  localparam int WARM_W     = 3;
  localparam int PHASE_W    = 2;

  localparam logic [GAIN_W-1:0]   GAIN_UNITY = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_UNITY;
  localparam logic [WARM_W-1:0]   WARM_FULL  = WARM_W'(HIST_DEPTH);
  localparam logic [PHASE_W-1:0]  PHASE_LAST = PHASE_W'(2);
  localparam logic [ACC_W-1:0]    NORM_BIAS  = ACC_W'((1 << NORM_SHIFT) - 1);
  localparam logic [PROD_W-1:0]   GAIN_BIAS  = PROD_W'((1 << GAIN_SHIFT) - 1);

  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [TAP_COUNT] = '{
    WEIGHT_W'(1), WEIGHT_W'(2), WEIGHT_W'(3), WEIGHT_W'(4),
    WEIGHT_W'(3), WEIGHT_W'(2), WEIGHT_W'(1)
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // filter output handed to the gain stage
  typedef struct packed {
    logic    valid;
    sample_t y;
  } fdg_y_t;

  function automatic sample_t sat_sample(input logic signed [SCALED_W-1:0] v);
    logic signed [SCALED_W-1:0] hi;
    logic signed [SCALED_W-1:0] lo;
    hi = SCALED_W'(32767);
    lo = -SCALED_W'(32768);
    if (v > hi) begin
      return sample_t'(16'sh7fff);
    end else if (v < lo) begin
      return sample_t'(16'sh8000);
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

>>> design/fdg_in_if.sv
interface fdg_in_if;
  import fdg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in_block;

  modport source (output valid, output sample_in, output last_in_block, input ready);
  modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

>>> design/fdg_out_if.sv
interface fdg_out_if;
  import fdg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> design/fir7_decimate3_gain.sv
// Seven-tap FIR (weights 1,2,3,4,3,2,1) decimating by three, with output gain.
// Input channel in_i carries one signed 16-bit sample per item plus a
// last_in_block flag; the sample after a flagged one starts a new block.
// Output channel out_o carries one filtered sample per produced result.
// A result comes from the item at block position 6, 9, 12, ... : weighted
// sum / 16 (toward zero), then times gain_q8_8 / 256 (toward zero),
// saturated. gain_q8_8 <= 256 passes the filter value unchanged.
// gain_q8_8 is written through gain_q8_8_we_i / gain_q8_8_i; the user must
// write it only while idle; the block does not enforce this.
// Throughput: one item per cycle while in_i.ready is high; tap cells update on
// every accepted item; results pass the filter, multiply and output registers.
// When the receiver stalls, each stage holds and ready falls back stage by
// stage, so up to three results can be in flight before in_i.ready drops.
// Reset clears block position, pipeline valids and sets the gain to 1.0;
// the sample chain is left as is, since no result reads it before six new
// samples of the block have passed through.
module fir7_decimate3_gain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fdg_in_if.sink                     in_i,
  fdg_out_if.source                  out_o,
  input  logic                       gain_q8_8_we_i,
  input  logic [fdg_pkg::GAIN_W-1:0] gain_q8_8_i
);
  import fdg_pkg::*;

  // gain register
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (gain_q8_8_we_i) begin
      gain_q <= gain_q8_8_i;
    end
  end

  // block position: warm count saturates at six, phase runs mod 3
  logic [WARM_W-1:0]  warm_q, warm_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               accept;
  logic               produce;
  logic               stg_ready;
  logic               v1_q;
  sample_t            y1_q;

  assign in_i.ready = !v1_q || stg_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign produce    = accept && (warm_q >= WARM_FULL) && (phase_q == '0);

  always_comb begin
    warm_d  = warm_q;
    phase_d = phase_q;
    if (accept) begin
      if (in_i.last_in_block) begin
        warm_d  = '0;
        phase_d = '0;
      end else begin
        if (warm_q < WARM_FULL) begin
          warm_d = warm_q + WARM_W'(1);
        end
        phase_d = (phase_q >= PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);
      end
    end
  end

  // transposed-form chain: cell k holds taps k..6 of the older samples,
  // so psum[1] is the whole window minus the newest sample
  acc_t psum [1:TAP_COUNT];
  assign psum[TAP_COUNT] = '0;

  for (genvar k = 1; k < TAP_COUNT; k++) begin : g_tap
    fdg_tap_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .x_i      (in_i.sample_in),
      .weight_i (TAP_WEIGHT[k]),
      .psum_i   (psum[k+1]),
      .psum_o   (psum[k])
    );
  end

  // newest sample joins the window; divide by 16 toward zero
  acc_t    acc;
  acc_t    acc_biased;
  sample_t y_d;

  assign acc        = ACC_W'(in_i.sample_in) * ACC_W'($signed({1'b0, TAP_WEIGHT[0]}))
                    + psum[1];
  assign acc_biased = acc + (acc[ACC_W-1] ? NORM_BIAS : '0);
  // |sum| <= 16 * 32768, so the quotient always fits in 16 bits
  assign y_d        = acc_biased[ACC_W-1:NORM_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q  <= '0;
      phase_q <= '0;
      v1_q    <= 1'b0;
    end else begin
      warm_q  <= warm_d;
      phase_q <= phase_d;
      if (in_i.ready) begin
        v1_q <= produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      y1_q <= y_d;
    end
  end

  fdg_y_t stg;
  assign stg.valid = v1_q;
  assign stg.y     = y1_q;

  fdg_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .stg_i       (stg),
    .stg_ready_o (stg_ready),
    .out_o       (out_o)
  );

  // checks
`include "fir7_decimate3_gain_macros.svh"

  `FDG_ASSERT(a_pos_range, clk_i, rst_ni, (warm_q <= WARM_FULL) && (phase_q <= PHASE_LAST), "block position out of range")
  `FDG_ASSERT_NEXT(a_block_restart, clk_i, rst_ni, accept && in_i.last_in_block, (warm_q == '0) && (phase_q == '0), "position not restarted after last item")
  `FDG_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, v1_q && !stg_ready, v1_q && $stable(y1_q), "filter stage lost a result while stalled")
  `FDG_ASSERT_IMPL(a_produce_warm, clk_i, rst_ni, produce, warm_q == WARM_FULL, "result before window filled")
endmodule

>>> design/fdg_tap_cell.sv
// One transposed-form tap: adds its weighted sample to the neighbour's sum.
module fdg_tap_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  fdg_pkg::sample_t              x_i,
  input  logic [fdg_pkg::WEIGHT_W-1:0]  weight_i,
  input  fdg_pkg::acc_t                 psum_i,
  output fdg_pkg::acc_t                 psum_o
);
  import fdg_pkg::*;

  acc_t term;
  acc_t psum_d;
  acc_t psum_q;

  assign term   = ACC_W'(x_i) * ACC_W'($signed({1'b0, weight_i}));
  assign psum_d = psum_i + term;
  assign psum_o = psum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psum_q <= psum_d;
    end
  end
endmodule

>>> design/fdg_gain.sv
// Gain multiply stage followed by the output register.
module fdg_gain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fdg_pkg::GAIN_W-1:0] gain_i,
  input  fdg_pkg::fdg_y_t            stg_i,
  output logic                       stg_ready_o,
  fdg_out_if.source                  out_o
);
  import fdg_pkg::*;

  logic                       v2_q;
  logic signed [PROD_W-1:0]   prod_q;
  sample_t                    y2_q;
  logic                       byp_q;
  logic                       out_v_q;
  sample_t                    out_q;
  logic                       ld_out;
  logic                       ld_mul;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   biased;
  logic signed [SCALED_W-1:0] scaled;
  sample_t                    res_d;

  assign ld_out      = !out_v_q || out_o.ready;
  assign ld_mul      = !v2_q || ld_out;
  assign stg_ready_o = ld_mul;

  assign prod_d = PROD_W'(stg_i.y) * $signed({1'b0, gain_i});
  // truncate toward zero: bias negatives before the arithmetic shift
  assign biased = prod_q + (prod_q[PROD_W-1] ? GAIN_BIAS : '0);
  assign scaled = biased[PROD_W-1:GAIN_SHIFT];
  assign res_d  = byp_q ? y2_q : sat_sample(scaled);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ld_mul) begin
        v2_q <= stg_i.valid;
      end
      if (ld_out) begin
        out_v_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_mul && stg_i.valid) begin
      prod_q <= prod_d;
      y2_q   <= stg_i.y;
      byp_q  <= (gain_i <= GAIN_UNITY);
    end
    if (ld_out && v2_q) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.sample_out = out_q;
endmodule
